// ----- sv/fglu_pkg.sv -----
// Shared types and constants for the font glyph lookup engine.
// No dependencies; imported by fglu_store and font_glyph_lookup_engine_unit.
package fglu_pkg;

  localparam int DEFAULT_FONT_BYTES = 4096;

  // Walk position width: holds a store position plus one record size (up to 2^32 + header).
  localparam int POS_W = 34;
  localparam int HEADER_LEN = 5;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_FIND  = 2'd1;
  localparam logic [1:0] OP_PIXEL = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] write_address;
    logic [7:0]  write_byte;
    logic [7:0]  char_code;
    logic [11:0] glyph_offset;
    logic [14:0] pixel_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] found_offset;
    logic [15:0] found_width;
    logic [15:0] found_height;
    logic [7:0]  pixel_value;
  } rsp_t;

endpackage

// ----- sv/fglu_store.sv -----
// Font store: single write port, one registered read port, and a copy of the
// smoothing flag held in byte 0. Depends on fglu_pkg.
module fglu_store import fglu_pkg::*; #(
  parameter int FONT_BYTES = DEFAULT_FONT_BYTES,
  localparam int AW = $clog2(FONT_BYTES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  output logic          smooth
);

  logic [7:0] mem [FONT_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // mirror byte 0 so the mode is known without a read cycle
  always_ff @(posedge clk) begin
    if (wr_en && wr_addr == '0) begin
      smooth <= (wr_data != 8'd0);
    end
  end

endmodule

// ----- sv/font_glyph_lookup_engine_unit.sv -----
// Font glyph lookup engine top level: request sequencer, record walk and
// response register. Depends on fglu_pkg and fglu_store.
//
// One request is handled at a time. req_stall is high during reset and while
// the sequencer is busy. It drops in the cycle after the response is loaded
// into the output register, so the next word can be taken at the following
// edge. The sequencer takes these steps before the response is loaded:
// - store write, unused operation, or search for code zero: none.
// - pixel read: one store read, or none when the address lies beyond the store.
// - find: for each record skipped, one code read, four header reads, a
//   width-by-height multiply and the position add, all through the single
//   read port of the store and the one multiplier. A matching record ends
//   after its header reads; a zero code or a header past the end stops the walk
//   after the code read, and a code position past the store stops it before that read.
// A response that waits in the output register holds the sequencer in its
// last state until the register frees. Byte 0 of the store picks smooth
// (nonzero) or mono mode.
module font_glyph_lookup_engine_unit import fglu_pkg::*; #(
  parameter int FONT_BYTES = DEFAULT_FONT_BYTES
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = $clog2(FONT_BYTES);
  localparam logic [POS_W-1:0] FB_POS = POS_W'(FONT_BYTES);
  localparam logic [16:0] FB_PIX = 17'(FONT_BYTES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CODE  = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_HDR   = 3'd3;
  localparam logic [2:0] S_MATCH = 3'd4;
  localparam logic [2:0] S_ADV   = 3'd5;
  localparam logic [2:0] S_PIX   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state;
  logic [POS_W-1:0] pos;
  logic [7:0]       code_q;
  logic             hit;
  logic [2:0]       cnt;
  logic [31:0]      hdr;
  logic [31:0]      prod;
  logic [2:0]       pix_bit;
  rsp_t             res;

  logic             accept;
  logic             out_free;
  logic             wr_en;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;
  logic             smooth;
  logic [16:0]      pix_addr;
  logic [POS_W-1:0] rec_size;
  logic [32:0]      prod_round;

  // response word carrying only a status
  function automatic rsp_t status_only(input logic [1:0] st);
    rsp_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  assign req_stall = rst || (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  assign wr_en = accept && req.operation == OP_WRITE
                 && {5'd0, req.write_address} < FB_PIX;

  assign pix_addr = {5'd0, req.glyph_offset}
                    + (smooth ? {2'd0, req.pixel_index} : {5'd0, req.pixel_index[14:3]});

  assign prod_round = {1'b0, prod} + 33'd7;
  assign rec_size   = smooth ? {2'd0, prod} : {4'd0, prod_round[32:3]};

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = pix_addr[AW-1:0];
      S_CHK:   rd_addr = AW'(pos + POS_W'(1));
      S_HDR:   rd_addr = (cnt == 3'd4) ? pos[AW-1:0] : AW'(pos + POS_W'(cnt) + POS_W'(1));
      default: rd_addr = pos[AW-1:0];
    endcase
  end

  fglu_store #(
    .FONT_BYTES(FONT_BYTES)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(AW'(req.write_address)),
    .wr_data(req.write_byte),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .smooth (smooth)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.operation)
              OP_WRITE: begin
                res   <= status_only(wr_en ? ST_OK : ST_RANGE);
                state <= S_DONE;
              end
              OP_FIND: begin
                code_q <= req.char_code;
                pos    <= POS_W'(1);
                if (req.char_code == 8'd0) begin
                  res   <= status_only(ST_NOT_FOUND);
                  state <= S_DONE;
                end else begin
                  res   <= '0;
                  state <= S_CODE;
                end
              end
              OP_PIXEL: begin
                pix_bit <= req.pixel_index[2:0];
                if (pix_addr >= FB_PIX) begin
                  res   <= status_only(ST_RANGE);
                  state <= S_DONE;
                end else begin
                  res   <= '0;
                  state <= S_PIX;
                end
              end
              default: begin
                res   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_CODE: begin
          if (pos >= FB_POS) begin
            res.status <= ST_RANGE;
            state      <= S_DONE;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          // rd_data holds the code byte of this record
          if (rd_data == 8'd0) begin
            res.status <= ST_NOT_FOUND;
            state      <= S_DONE;
          end else if (pos + POS_W'(HEADER_LEN - 1) >= FB_POS) begin
            res.status <= ST_RANGE;
            state      <= S_DONE;
          end else begin
            hit   <= (rd_data == code_q);
            cnt   <= 3'd1;
            state <= S_HDR;
          end
        end
        S_HDR: begin
          hdr <= {hdr[23:0], rd_data};
          if (cnt == 3'd4) begin
            state <= S_MATCH;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_MATCH: begin
          if (hit) begin
            if (pos + POS_W'(HEADER_LEN) >= FB_POS) begin
              res <= status_only(ST_RANGE);
            end else begin
              res <= {ST_OK, 12'(pos + POS_W'(HEADER_LEN)), hdr, 8'd0};
            end
            state <= S_DONE;
          end else begin
            prod  <= hdr[31:16] * hdr[15:0];
            state <= S_ADV;
          end
        end
        S_ADV: begin
          // skip header and bitmap of a record that did not match
          pos   <= pos + rec_size + POS_W'(HEADER_LEN);
          state <= S_CODE;
        end
        S_PIX: begin
          if (smooth) begin
            res.pixel_value <= rd_data;
          end else begin
            res.pixel_value <= rd_data[pix_bit] ? 8'hff : 8'h00;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // response register: load from the sequencer, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp <= res;
    end
  end

endmodule
